// ===== hdl/dbd_pkg.sv =====
package dbd_pkg;

  // Field widths
  localparam int VAL_W      = 32;
  localparam int IMG_W      = 8;
  localparam int CLS_W      = 10;
  localparam int SCORE_W    = 17;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 11;
  localparam int SIZE_W     = 13;
  localparam int POS_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int PROD_W     = 2 * VAL_W;

  // Divider operands: signed numerator, magnitude, divisor of twice the model size
  localparam int NUM_W = 34;
  localparam int MAG_W = NUM_W - 1;
  localparam int DEN_W = SIZE_W + 1;

  localparam int DEF_MAX_CLASSES = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASSES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd4;

  // Mode codes (end-to-end is any code with the upper bit set)
  localparam logic [MODE_W-1:0] MODE_OBJ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLS = 2'd1;

  // Register reset values
  localparam logic [MODE_W-1:0]  RST_MODE      = MODE_OBJ;
  localparam logic [SCORE_W-1:0] RST_THRESHOLD = 17'd32768;
  localparam logic [CNT_W-1:0]   RST_CLASSES   = 11'd80;
  localparam logic [SIZE_W-1:0]  RST_SIZE      = 13'd640;

  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_START,
    ST_WAIT,
    ST_HOLD
  } seq_state_t;

  // Datapath status toward the sequencer
  typedef struct packed {
    logic in_valid;
    logic go_mul;
    logic go_div;
    logic mul_pass;
    logic div_done;
    logic out_free;
  } seq_status_t;

  // Sequencer strobes toward the datapath
  typedef struct packed {
    logic       in_ready;
    logic       accept;
    logic       load_score;
    logic       load_num;
    logic       div_start;
    logic       store_corner;
    logic       load_out;
    logic [1:0] corner;
  } seq_ctrl_t;

endpackage

// ===== hdl/dbd_div.sv =====
module dbd_div import dbd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quot
);

  localparam int CW = $clog2(MAG_W + 1);

  logic                    busy_r;
  logic                    fin_r;
  logic                    done_r;
  logic                    neg_r;
  logic [CW-1:0]           cnt_r;
  logic [DEN_W-1:0]        den_r;
  logic [DEN_W-1:0]        rem_r;
  logic [MAG_W-1:0]        dvd_r;
  logic signed [NUM_W-1:0] quot_r;

  logic [NUM_W-1:0] num_abs;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;
  logic [NUM_W-1:0] q_mag;

  // One quotient bit per cycle, restoring
  assign num_abs = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
  assign rem_sh  = {rem_r, dvd_r[MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});
  // floor for negative numerators: bump magnitude when remainder is nonzero
  assign q_mag   = {1'b0, dvd_r} + NUM_W'(rem_r != '0);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= num_abs[MAG_W-1:0];
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[MAG_W-2:0], ge};
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
    if (fin_r) begin
      quot_r <= neg_r ? (~q_mag + NUM_W'(1)) : {1'b0, dvd_r};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== hdl/dbd_seq.sv =====
module dbd_seq import dbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  seq_status_t status,
  output seq_ctrl_t   ctrl
);

  seq_state_t state_r, state_nxt;
  logic [1:0] corner_r, corner_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
    end
  end

  // Next state: item intake, optional product check, four divisions, result handoff
  always_comb begin
    state_nxt  = state_r;
    corner_nxt = corner_r;
    case (state_r)
      ST_IDLE: begin
        corner_nxt = '0;
        if (status.in_valid) begin
          if (status.go_mul) begin
            state_nxt = ST_MUL;
          end else if (status.go_div) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_MUL:   state_nxt = status.mul_pass ? ST_PREP : ST_IDLE;
      ST_PREP:  state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (status.div_done) begin
          if (corner_r == 2'd3) begin
            state_nxt = ST_HOLD;
          end else begin
            corner_nxt = corner_r + 2'd1;
            state_nxt  = ST_PREP;
          end
        end
      end
      ST_HOLD: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Strobes
  always_comb begin
    ctrl        = '0;
    ctrl.corner = corner_r;
    case (state_r)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.accept   = status.in_valid;
      end
      ST_MUL:   ctrl.load_score   = 1'b1;
      ST_PREP:  ctrl.load_num     = 1'b1;
      ST_START: ctrl.div_start    = 1'b1;
      ST_WAIT:  ctrl.store_corner = status.div_done;
      ST_HOLD:  ctrl.load_out     = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hdl/detection_box_decoder_unit.sv =====
// Detection box decoder. Takes a detector output row one signed Q16.16 value
// per item and emits at most one candidate (image, class, score, normalized
// box) per item. An item that emits nothing is taken without a stall, but a
// class score in objectness mode first goes through the multiplier register
// while the input is stalled. An emitting item holds the input stalled
// while its four box edges go one after another through a single 33-step
// shift-subtract divider, which sets the pace. A finished candidate waits
// in the output register, so the next item can be taken while it is still
// stalled downstream. Configuration must be written through the cfg port
// only while idle; the block does not enforce it. Writes are always ready.
module detection_box_decoder_unit import dbd_pkg::*; #(
  parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic [IMG_W-1:0]         in_image_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IMG_W-1:0]         out_image_out,
  output logic [CLS_W-1:0]         out_class_id,
  output logic [SCORE_W-1:0]       out_score,
  output logic signed [VAL_W-1:0]  out_left,
  output logic signed [VAL_W-1:0]  out_top,
  output logic signed [VAL_W-1:0]  out_right,
  output logic signed [VAL_W-1:0]  out_bottom,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [POS_W:0] MAX_C = (POS_W + 1)'(MAX_CLASSES);

  // Configuration registers
  logic [MODE_W-1:0]  mode_r;
  logic [SCORE_W-1:0] thr_r;
  logic [CNT_W-1:0]   cc_r;
  logic [SIZE_W-1:0]  mw_r;
  logic [SIZE_W-1:0]  mh_r;

  // Row state
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] box_r [4];
  logic signed [VAL_W-1:0] wt_r;

  // Candidate being built
  logic signed [PROD_W-1:0] prod_r;
  logic [IMG_W-1:0]         cand_img_r;
  logic [CLS_W-1:0]         cand_cls_r;
  logic [SCORE_W-1:0]       cand_score_r;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [VAL_W-1:0]  res_r [4];

  // Output register
  logic                     out_valid_r;
  logic [IMG_W-1:0]         out_img_r;
  logic [CLS_W-1:0]         out_cls_r;
  logic [SCORE_W-1:0]       out_score_r;
  logic signed [VAL_W-1:0]  out_box_r [4];

  seq_status_t status;
  seq_ctrl_t   ctrl;

  logic                    e2e;
  logic                    obj_mode;
  logic [SIZE_W-1:0]       mw_eff;
  logic [SIZE_W-1:0]       mh_eff;
  logic [POS_W:0]          cc_ext;
  logic [POS_W:0]          eff_cls;
  logic [POS_W-1:0]        row_len;
  logic [POS_W-1:0]        pos_eff;
  logic [POS_W-1:0]        pos_inc;
  logic [POS_W-1:0]        pos_nxt;
  logic                    is_box;
  logic                    is_weight;
  logic                    is_cls;
  logic                    e2e_emit;
  logic                    cls_pass;
  logic signed [VAL_W-1:0] thr_s;
  logic [CLS_W-1:0]        e2e_cls;
  logic [CLS_W-1:0]        cls_sel;
  logic [SCORE_W-1:0]      score_sel;
  logic [SCORE_W-1:0]      prod_score;
  logic                    mul_pass;

  logic [1:0]              k;
  logic [SIZE_W-1:0]       m_sel;
  logic signed [NUM_W-1:0] ctr_x;
  logic signed [NUM_W-1:0] sz_x;
  logic signed [NUM_W-1:0] bx_x;
  logic signed [NUM_W-1:0] m_x;
  logic signed [NUM_W-1:0] lim_x;
  logic signed [NUM_W-1:0] lo;
  logic signed [NUM_W-1:0] hi;
  logic signed [NUM_W-1:0] lo_cl;
  logic signed [NUM_W-1:0] hi_cl;
  logic signed [NUM_W-1:0] num_nxt;
  logic                    div_done;
  logic signed [NUM_W-1:0] quot;
  logic [VAL_W-1:0]        corner_val;
  logic                    q_ovf;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RST_MODE;
      thr_r  <= RST_THRESHOLD;
      cc_r   <= RST_CLASSES;
      mw_r   <= RST_SIZE;
      mh_r   <= RST_SIZE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:      mode_r <= cfg_data[MODE_W-1:0];
        CFG_THRESHOLD: thr_r  <= cfg_data[SCORE_W-1:0];
        CFG_CLASSES:   cc_r   <= cfg_data[CNT_W-1:0];
        CFG_WIDTH:     mw_r   <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:    mh_r   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Row layout
  assign e2e      = mode_r[1];
  assign obj_mode = (mode_r == MODE_OBJ);
  assign mw_eff   = (mw_r == '0) ? SIZE_W'(1) : mw_r;
  assign mh_eff   = (mh_r == '0) ? SIZE_W'(1) : mh_r;
  assign cc_ext   = (POS_W + 1)'(cc_r);
  assign eff_cls  = (cc_ext < MAX_C) ? cc_ext : MAX_C;
  assign row_len  = e2e ? POS_W'(6)
                  : (eff_cls[POS_W-1:0] + (obj_mode ? POS_W'(5) : POS_W'(4)));
  assign pos_eff  = (pos_r >= row_len) ? '0 : pos_r;
  assign pos_inc  = pos_eff + POS_W'(1);
  assign pos_nxt  = (pos_inc >= row_len) ? '0 : pos_inc;

  // Element classification
  assign thr_s     = $signed({{(VAL_W - SCORE_W){1'b0}}, thr_r});
  assign is_box    = (pos_eff < POS_W'(4));
  assign is_weight = !is_box && (pos_eff == POS_W'(4)) && (e2e || obj_mode);
  assign is_cls    = !is_box && !e2e && !is_weight;
  assign e2e_emit  = !is_box && e2e && (pos_eff != POS_W'(4)) && (wt_r >= thr_s);
  assign cls_pass  = is_cls && !obj_mode && (in_value > thr_s);

  // Class and score of the candidate
  assign e2e_cls = in_value[VAL_W-1] ? '0
                 : (|in_value[30:26]) ? {CLS_W{1'b1}} : in_value[25:16];
  always_comb begin
    if (e2e) begin
      cls_sel   = e2e_cls;
      score_sel = (wt_r > $signed(VAL_W'(SCORE_ONE))) ? SCORE_ONE : wt_r[SCORE_W-1:0];
    end else begin
      cls_sel   = obj_mode ? CLS_W'(pos_eff - POS_W'(5)) : CLS_W'(pos_eff - POS_W'(4));
      score_sel = (in_value > $signed(VAL_W'(SCORE_ONE))) ? SCORE_ONE
                : in_value[SCORE_W-1:0];
    end
  end

  // Objectness product check
  assign mul_pass   = prod_r > $signed({31'b0, thr_r, 16'b0});
  assign prod_score = (prod_r[PROD_W-2:16] > (PROD_W - 17)'(SCORE_ONE)) ? SCORE_ONE
                    : prod_r[32:16];

  // Item intake and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      wt_r  <= '0;
      for (int i = 0; i < 4; i++) begin
        box_r[i] <= '0;
      end
    end else if (ctrl.accept) begin
      pos_r <= pos_nxt;
      if (is_box) begin
        box_r[pos_eff[1:0]] <= in_value;
      end
      if (is_weight) begin
        wt_r <= in_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      prod_r       <= wt_r * in_value;
      cand_img_r   <= in_image_index;
      cand_cls_r   <= cls_sel;
      cand_score_r <= score_sel;
    end else if (ctrl.load_score) begin
      cand_score_r <= prod_score;
    end
  end

  // Numerator for the current edge: corner, clamp (except in end-to-end mode), rounding offset
  assign k      = ctrl.corner;
  assign m_sel  = k[0] ? mh_eff : mw_eff;
  assign ctr_x  = NUM_W'(box_r[{1'b0, k[0]}]);
  assign sz_x   = NUM_W'(box_r[{1'b1, k[0]}]);
  assign bx_x   = NUM_W'(box_r[k]);
  assign m_x    = $signed(NUM_W'(m_sel));
  assign lim_x  = $signed(NUM_W'({m_sel, 17'b0}));
  assign lo     = (ctr_x <<< 1) - sz_x;
  assign hi     = (ctr_x <<< 1) + sz_x;
  assign lo_cl  = lo[NUM_W-1] ? '0 : lo;
  assign hi_cl  = (hi > lim_x) ? lim_x : hi;
  assign num_nxt = e2e ? ((bx_x <<< 1) + m_x) : ((k[1] ? hi_cl : lo_cl) + m_x);

  always_ff @(posedge clk) begin
    if (ctrl.load_num) begin
      num_r <= num_nxt;
    end
  end

  dbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.div_start),
    .num   (num_r),
    .den   ({m_sel, 1'b0}),
    .done  (div_done),
    .quot  (quot)
  );

  // Edge result: unit clamp in end-to-end mode, 32-bit saturation otherwise
  assign q_ovf = !((&quot[NUM_W-1:VAL_W-1]) || !(|quot[NUM_W-1:VAL_W-1]));
  always_comb begin
    if (e2e) begin
      if (quot[NUM_W-1]) begin
        corner_val = '0;
      end else if (quot > $signed(NUM_W'(SCORE_ONE))) begin
        corner_val = VAL_W'(SCORE_ONE);
      end else begin
        corner_val = quot[VAL_W-1:0];
      end
    end else if (q_ovf) begin
      corner_val = quot[NUM_W-1] ? {1'b1, {(VAL_W - 1){1'b0}}} : {1'b0, {(VAL_W - 1){1'b1}}};
    end else begin
      corner_val = quot[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.store_corner) begin
      res_r[k] <= corner_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_img_r   <= cand_img_r;
      out_cls_r   <= cand_cls_r;
      out_score_r <= cand_score_r;
      for (int i = 0; i < 4; i++) begin
        out_box_r[i] <= res_r[i];
      end
    end
  end

  // Sequencer
  assign status.in_valid = in_valid;
  assign status.go_mul   = is_cls && obj_mode;
  assign status.go_div   = e2e_emit || cls_pass;
  assign status.mul_pass = mul_pass;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || !out_stall;

  dbd_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_stall      = !ctrl.in_ready;
  assign out_valid     = out_valid_r;
  assign out_image_out = out_img_r;
  assign out_class_id  = out_cls_r;
  assign out_score     = out_score_r;
  assign out_left      = out_box_r[0];
  assign out_top       = out_box_r[1];
  assign out_right     = out_box_r[2];
  assign out_bottom    = out_box_r[3];

endmodule

// ===== hdl/dbd_checker.sv =====
module dbd_checker import dbd_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [IMG_W-1:0]        out_image_out,
  input logic [CLS_W-1:0]        out_class_id,
  input logic [SCORE_W-1:0]      out_score,
  input logic signed [VAL_W-1:0] out_left,
  input logic signed [VAL_W-1:0] out_top,
  input logic signed [VAL_W-1:0] out_right,
  input logic signed [VAL_W-1:0] out_bottom
);

  // A stalled item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_image_out) &&
      $stable(out_class_id) && $stable(out_score) && $stable(out_left) &&
      $stable(out_top) && $stable(out_right) && $stable(out_bottom))
    else $error("result item changed while stalled");

  // Reset leaves the block ready with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // A new result only comes out of a busy period
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a division run");

  // Taking an item never produces a result on the very next edge
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared right after intake");

endmodule

bind detection_box_decoder_unit dbd_checker u_dbd_checker (.*);
